[rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg
// Types and fixed constants shared by the travel calibrator and its divider.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int unsigned DIV_W  = 20;
    localparam int unsigned DIV_CW = $clog2(DIV_W);

    localparam logic [15:0] MAX16       = 16'hFFFF;
    localparam logic [18:0] MAX19       = 19'h7FFFF;
    localparam logic [19:0] MAX20       = 20'hFFFFF;
    localparam logic [19:0] RATIO_RESET = 20'd204;
    localparam logic [3:0]  MULT_RESET  = 4'd4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEEK = 2'd1,
        MODE_DOWN = 2'd2,
        MODE_UP   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_WAIT_IN,
        S_CALC,
        S_CHECK,
        S_HALF,
        S_SUM,
        S_FINAL,
        S_AVG_GO,
        S_AVG_WAIT,
        S_RAT_GO,
        S_RAT_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/stc_divider.sv]
// ----------------------------------------------------------------------------
// stc_divider
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module stc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stc_pkg::t_div_req i_req,
    output stc_pkg::t_div_rsp o_rsp
);
    import stc_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_dsr, n_dsr;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    // dividend bits shift out of the top of r_quo as quotient bits enter below
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            if (!diff[DIV_W]) begin
                n_rem = diff[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CW'(DIV_W-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[rtl/stepper_travel_calibrator.sv]
// ----------------------------------------------------------------------------
// stepper_travel_calibrator
// Travel calibration sequencer for a stepper-driven door.
// ----------------------------------------------------------------------------
// Usage: one input transfer per motor tick (start request, both limit
// switches, encoder pulse count) produces exactly one result transfer
// (coil phase, coil update, mode, stall flag, calibrated flag, round,
// average and step ratio), in order. The stall multiplier is to be written
// through i_cfg_we/i_cfg_wdata only while the block is idle; the block does
// not enforce this. An ordinary tick passes the calc state on its way to
// the result register; a pass that steps also checks for a stall, and an
// up pass that reaches the top limit first folds the half-sum into the
// round sum. The tick that closes the last round then runs the bit-serial
// divider twice (round sum / ROUNDS, then steps / average, when nonzero).
// Input stall is low only while the sequencer waits for a tick; results sit
// in an output register, so the next tick is taken while one waits there.
// If the receiver stalls, the finished tick holds until the register frees.
// Synchronous reset restores mode idle, phase 0, ratio 204, multiplier 4,
// and empties the output register.
// ----------------------------------------------------------------------------
module stepper_travel_calibrator #(
    parameter int PHASES = 8,
    parameter int ROUNDS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_request,
    input  logic        i_top_limit_hit,
    input  logic        i_bottom_limit_hit,
    input  logic [3:0]  i_encoder_pulses,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_coil_phase,
    output logic        o_coil_update,
    output logic [1:0]  o_mode_code,
    output logic        o_stall_error,
    output logic        o_is_calibrated,
    output logic [2:0]  o_round_number,
    output logic [15:0] o_average_count,
    output logic [19:0] o_step_ratio
);
    import stc_pkg::*;

    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    logic [3:0]  r_mult;
    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_round, n_round;
    logic [15:0] r_pass, n_pass;
    logic [15:0] r_down, n_down;
    logic [18:0] r_rsum, n_rsum;
    logic [19:0] r_rsteps, n_rsteps;
    logic [19:0] r_ssp, n_ssp;
    logic [19:0] r_ratio, n_ratio;
    logic [15:0] r_avg, n_avg;
    logic        r_done, n_done;
    logic        r_upd, n_upd;
    logic        r_stl, n_stl;
    logic [15:0] r_half, n_half;
    logic [23:0] r_limit;

    logic        r_start, r_top, r_bot;
    logic [3:0]  r_pulses;
    logic        r_out_valid;

    logic        in_xfer, out_xfer, emit;
    logic        upward, at_limit, is_pass;
    logic [2:0]  phase_up, phase_dn;
    logic [16:0] pass_sum;
    logic [16:0] half_sum;
    logic [19:0] rsum_sum;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    stc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_WAIT_IN);
    assign emit = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    assign upward   = (r_mode == MODE_UP) || (r_mode == MODE_SEEK);
    assign is_pass  = (r_mode == MODE_DOWN) || (r_mode == MODE_UP);
    assign at_limit = upward ? r_top : r_bot;
    assign phase_up = (r_phase == 3'(PHASES-1)) ? 3'd0 : r_phase + 3'd1;
    assign phase_dn = (r_phase == 3'd0) ? 3'(PHASES-1) : r_phase - 3'd1;
    assign pass_sum = {1'b0, r_pass} + {13'd0, r_pulses};
    assign half_sum = {1'b0, r_down} + {1'b0, r_pass};
    assign rsum_sum = {1'b0, r_rsum} + {4'd0, r_half};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_WAIT_IN: if (in_xfer) n_state = S_CALC;
            S_CALC: begin
                if (r_mode == MODE_IDLE || r_mode == MODE_SEEK) n_state = S_EMIT;
                else if (!at_limit) n_state = S_CHECK;
                else if (r_mode == MODE_DOWN) n_state = S_EMIT;
                else n_state = S_HALF;
            end
            S_CHECK:   n_state = S_EMIT;
            S_HALF:    n_state = S_SUM;
            S_SUM:     n_state = S_FINAL;
            S_FINAL: begin
                if (r_round >= 3'(ROUNDS-1)) n_state = S_AVG_GO;
                else n_state = S_EMIT;
            end
            S_AVG_GO:  n_state = S_AVG_WAIT;
            S_AVG_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient[15:0] == 16'd0) n_state = S_EMIT;
                    else n_state = S_RAT_GO;
                end
            end
            S_RAT_GO:  n_state = S_RAT_WAIT;
            S_RAT_WAIT: if (div_rsp.done) n_state = S_EMIT;
            S_EMIT:    if (emit) n_state = S_WAIT_IN;
            default:   n_state = S_WAIT_IN;
        endcase
    end

    // datapath and divider requests
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_round  = r_round;
        n_pass   = r_pass;
        n_down   = r_down;
        n_rsum   = r_rsum;
        n_rsteps = r_rsteps;
        n_ssp    = r_ssp;
        n_ratio  = r_ratio;
        n_avg    = r_avg;
        n_done   = r_done;
        n_upd    = r_upd;
        n_stl    = r_stl;
        n_half   = r_half;
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, r_rsum};
        div_req.divisor  = DIV_W'(ROUNDS);
        case (r_state)
            S_WAIT_IN: begin
                if (in_xfer) begin
                    n_upd = 1'b0;
                    n_stl = 1'b0;
                end
            end
            S_CALC: begin
                if (r_mode == MODE_IDLE) begin
                    if (r_start && !r_done) n_mode = MODE_SEEK;
                end else begin
                    if (!at_limit) begin
                        n_phase  = upward ? phase_up : phase_dn;
                        n_rsteps = (r_rsteps == MAX20) ? r_rsteps : r_rsteps + 20'd1;
                        n_ssp    = (r_ssp == MAX20) ? r_ssp : r_ssp + 20'd1;
                        n_upd    = 1'b1;
                    end
                    if (r_pulses != 4'd0) begin
                        n_ssp = '0;
                        if (is_pass) n_pass = pass_sum[16] ? MAX16 : pass_sum[15:0];
                    end
                    if (r_mode == MODE_SEEK) begin
                        if (r_top) begin
                            n_round  = '0;
                            n_rsum   = '0;
                            n_pass   = '0;
                            n_rsteps = '0;
                            n_mode   = MODE_DOWN;
                        end
                    end else if (at_limit && r_mode == MODE_DOWN) begin
                        n_down = (r_pulses != 4'd0)
                                 ? (pass_sum[16] ? MAX16 : pass_sum[15:0]) : r_pass;
                        n_pass = '0;
                        n_mode = MODE_UP;
                    end
                end
            end
            S_CHECK: begin
                if ({4'd0, r_ssp} > r_limit) begin
                    n_phase = '0;
                    n_done  = 1'b0;
                    n_mode  = MODE_IDLE;
                    n_stl   = 1'b1;
                end
            end
            S_HALF: n_half = half_sum[16:1];
            S_SUM: begin
                n_rsum = rsum_sum[19] ? MAX19 : rsum_sum[18:0];
                n_pass = '0;
            end
            S_FINAL: begin
                if (r_round < 3'(ROUNDS-1)) begin
                    n_round  = r_round + 3'd1;
                    n_rsteps = '0;
                    n_mode   = MODE_DOWN;
                end
            end
            S_AVG_GO: div_req.start = 1'b1;
            S_AVG_WAIT: begin
                if (div_rsp.done) begin
                    n_avg = div_rsp.quotient[15:0];
                    if (div_rsp.quotient[15:0] == 16'd0) begin
                        n_ratio = MAX20;
                        n_done  = 1'b1;
                        n_mode  = MODE_IDLE;
                    end
                end
            end
            S_RAT_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_rsteps;
                div_req.divisor  = {4'd0, r_avg};
            end
            S_RAT_WAIT: begin
                if (div_rsp.done) begin
                    n_ratio = div_rsp.quotient;
                    n_done  = 1'b1;
                    n_mode  = MODE_IDLE;
                end
            end
            S_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WAIT_IN;
            r_mode      <= MODE_IDLE;
            r_mult      <= MULT_RESET;
            r_phase     <= '0;
            r_round     <= '0;
            r_pass      <= '0;
            r_down      <= '0;
            r_rsum      <= '0;
            r_rsteps    <= '0;
            r_ssp       <= '0;
            r_ratio     <= RATIO_RESET;
            r_avg       <= '0;
            r_done      <= 1'b0;
            r_upd       <= 1'b0;
            r_stl       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_phase  <= n_phase;
            r_round  <= n_round;
            r_pass   <= n_pass;
            r_down   <= n_down;
            r_rsum   <= n_rsum;
            r_rsteps <= n_rsteps;
            r_ssp    <= n_ssp;
            r_ratio  <= n_ratio;
            r_avg    <= n_avg;
            r_done   <= n_done;
            r_upd    <= n_upd;
            r_stl    <= n_stl;
            if (i_cfg_we) r_mult <= i_cfg_wdata;
            if (emit) r_out_valid <= 1'b1;
            else if (out_xfer) r_out_valid <= 1'b0;
        end
        r_half  <= n_half;
        // stall threshold, registered ahead of the compare
        r_limit <= r_ratio * r_mult;
        if (in_xfer) begin
            r_start  <= i_start_request;
            r_top    <= i_top_limit_hit;
            r_bot    <= i_bottom_limit_hit;
            r_pulses <= i_encoder_pulses;
        end
        if (emit) begin
            o_coil_phase    <= r_phase;
            o_coil_update   <= r_upd;
            o_mode_code     <= r_mode;
            o_stall_error   <= r_stl;
            o_is_calibrated <= r_done;
            o_round_number  <= r_round;
            o_average_count <= r_avg;
            o_step_ratio    <= r_ratio;
        end
    end

    assign o_out_valid = r_out_valid;

    a_stall_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stall_error) |-> (o_mode_code == MODE_IDLE && !o_is_calibrated))
        else $error("stall result not idle or still calibrated");

    a_idle_update_is_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_coil_update && o_mode_code == MODE_IDLE) |-> o_stall_error)
        else $error("coil driven in idle without a stall");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || out_xfer))
        else $error("result register overwritten");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stepper travel calibrator. A local predictor
// tracks mode, phase, pass counters and ratio for every tick transfer taken
// by the block. Each result transfer is compared field by field with the
// oldest predicted tick. The stimulus runs two directed rounds, then stall
// thresholds at both multiplier extremes, then random calibration attempts
// that each end in a stall, and finally one full calibration.
// ----------------------------------------------------------------------------
module tb_top;

    import stc_pkg::*;

    localparam int NUM_PHASES     = 8;
    localparam int NUM_ROUNDS     = 3;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_TICKS   = 600;
    localparam int STALL_RUN_CAP  = 250;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        logic       start;
        logic       top;
        logic       bottom;
        logic [3:0] pulses;
    } t_tick_in;

    typedef struct packed {
        logic [2:0]  phase;
        logic        update;
        t_mode       mode;
        logic        stall;
        logic        calibrated;
        logic [2:0]  round_num;
        logic [15:0] average;
        logic [19:0] ratio;
    } t_tick_out;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        in_valid  = 1'b0;
    logic        in_start  = 1'b0;
    logic        in_top    = 1'b0;
    logic        in_bottom = 1'b0;
    logic [3:0]  in_pulses = 4'd0;
    logic        out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_coil_phase;
    logic        o_coil_update;
    logic [1:0]  o_mode_code;
    logic        o_stall_error;
    logic        o_is_calibrated;
    logic [2:0]  o_round_number;
    logic [15:0] o_average_count;
    logic [19:0] o_step_ratio;

    // predictor state
    t_mode       cal_mode   = MODE_IDLE;
    logic [2:0]  cal_phase  = '0;
    logic [2:0]  cal_round  = '0;
    logic [15:0] cal_pass   = '0;
    logic [15:0] cal_down   = '0;
    logic [18:0] cal_sum    = '0;
    logic [19:0] cal_steps  = '0;
    logic [19:0] cal_blind  = '0;
    logic [19:0] cal_ratio  = RATIO_RESET;
    logic [15:0] cal_avg    = '0;
    logic        cal_done   = 1'b0;
    logic [3:0]  cal_mult   = MULT_RESET;

    t_tick_out   due_outputs[$];
    t_tick_out   head_out;

    int          fail_count        = 0;
    int          results_seen      = 0;
    int          live_ticks        = 0;
    int          stalls_predicted  = 0;
    int          calibrations_done = 0;
    int          cfg_writes        = 0;
    int          burst_left        = 0;
    int          idle_cycles       = 0;

    // receiver pattern
    bit          long_hold_req = 1'b0;
    int          hold_left     = 0;
    int          pattern_left  = 0;
    int          stall_pct     = 0;

    stepper_travel_calibrator #(
        .PHASES (NUM_PHASES),
        .ROUNDS (NUM_ROUNDS)
    ) u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_start_request    (in_start),
        .i_top_limit_hit    (in_top),
        .i_bottom_limit_hit (in_bottom),
        .i_encoder_pulses   (in_pulses),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_coil_phase       (o_coil_phase),
        .o_coil_update      (o_coil_update),
        .o_mode_code        (o_mode_code),
        .o_stall_error      (o_stall_error),
        .o_is_calibrated    (o_is_calibrated),
        .o_round_number     (o_round_number),
        .o_average_count    (o_average_count),
        .o_step_ratio       (o_step_ratio)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void step_coils(bit upward);
        int unsigned ph;
        ph = cal_phase;
        if (upward) begin
            cal_phase = 3'((ph + 1) % NUM_PHASES);
        end else begin
            cal_phase = 3'((ph + NUM_PHASES - 1) % NUM_PHASES);
        end
        if (cal_steps != MAX20) cal_steps = cal_steps + 1'b1;
        if (cal_blind != MAX20) cal_blind = cal_blind + 1'b1;
    endfunction

    task automatic predict_tick(input t_tick_in t);
        t_tick_out       r;
        t_mode           prior;
        bit              upward;
        bit              at_limit;
        int unsigned     acc;
        longint unsigned stall_lim;
        prior    = cal_mode;
        r        = '0;
        case (cal_mode)
            MODE_IDLE: begin
                if (t.start && !cal_done) cal_mode = MODE_SEEK;
            end
            MODE_SEEK: begin
                if (!t.top) begin
                    step_coils(1'b1);
                    r.update = 1'b1;
                end
                if (t.pulses != 0) cal_blind = '0;
                if (t.top) begin
                    cal_round = '0;
                    cal_sum   = '0;
                    cal_pass  = '0;
                    cal_steps = '0;
                    cal_mode  = MODE_DOWN;
                end
            end
            default: begin
                upward   = (cal_mode == MODE_UP);
                at_limit = upward ? t.top : t.bottom;
                if (!at_limit) begin
                    step_coils(upward);
                    r.update = 1'b1;
                end
                if (t.pulses != 0) begin
                    acc       = cal_pass + t.pulses;
                    cal_pass  = (acc > MAX16) ? MAX16 : acc[15:0];
                    cal_blind = '0;
                end
                if (!at_limit) begin
                    stall_lim = cal_ratio * cal_mult;
                    if (cal_blind > stall_lim) begin
                        cal_phase = '0;
                        cal_done  = 1'b0;
                        cal_mode  = MODE_IDLE;
                        r.stall   = 1'b1;
                    end
                end else if (!upward) begin
                    cal_down = cal_pass;
                    cal_pass = '0;
                    cal_mode = MODE_UP;
                end else begin
                    // round closes on the top limit: fold the half-sum in
                    acc      = cal_down + cal_pass;
                    acc      = cal_sum + (acc >> 1);
                    cal_sum  = (acc > MAX19) ? MAX19 : acc[18:0];
                    cal_pass = '0;
                    if (cal_round >= NUM_ROUNDS - 1) begin
                        cal_avg   = 16'(cal_sum / NUM_ROUNDS);
                        cal_ratio = (cal_avg == 0) ? MAX20 : 20'(cal_steps / cal_avg);
                        cal_done  = 1'b1;
                        cal_mode  = MODE_IDLE;
                        calibrations_done++;
                    end else begin
                        cal_round = cal_round + 1'b1;
                        cal_steps = '0;
                        cal_mode  = MODE_DOWN;
                    end
                end
            end
        endcase
        r.phase      = cal_phase;
        r.mode       = cal_mode;
        r.calibrated = cal_done;
        r.round_num  = cal_round;
        r.average    = cal_avg;
        r.ratio      = cal_ratio;
        if (!(prior == MODE_IDLE && cal_mode == MODE_IDLE)) live_ticks++;
        if (r.stall) stalls_predicted++;
        due_outputs.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_tick_in make_tick(bit start, bit top, bit bottom, logic [3:0] pulses);
        t_tick_in t;
        t.start  = start;
        t.top    = top;
        t.bottom = bottom;
        t.pulses = pulses;
        return t;
    endfunction

    function automatic logic [3:0] pick_pulses(int zero_pct, int max_p);
        if ($urandom_range(1, 100) <= zero_pct) return 4'd0;
        return 4'($urandom_range(1, max_p));
    endfunction

    // tick for the current travel; the limit not being awaited is noise
    function automatic t_tick_in pass_tick(bit at_limit, int zero_pct, int max_p);
        t_tick_in t;
        t.start  = 1'($urandom_range(0, 1));
        t.pulses = pick_pulses(zero_pct, max_p);
        if (cal_mode == MODE_DOWN) begin
            t.bottom = at_limit;
            t.top    = 1'($urandom_range(0, 1));
        end else begin
            t.top    = at_limit;
            t.bottom = 1'($urandom_range(0, 1));
        end
        return t;
    endfunction

    function automatic t_tick_in noise_tick(bit start);
        return make_tick(start, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         4'($urandom_range(0, 15)));
    endfunction

    task automatic send_tick(input t_tick_in t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        in_start  <= t.start;
        in_top    <= t.top;
        in_bottom <= t.bottom;
        in_pulses <= t.pulses;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        predict_tick(t);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // caller makes sure nothing is in flight
    task automatic set_multiplier(input logic [3:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cal_mult  = m;
        cfg_writes++;
    endtask

    task automatic drive_travel(int steps, int zero_pct, int max_p, bit close);
        for (int i = 0; i < steps && cal_mode != MODE_IDLE; i++) begin
            send_tick(pass_tick(1'b0, zero_pct, max_p));
        end
        if (close && cal_mode != MODE_IDLE) send_tick(pass_tick(1'b1, zero_pct, max_p));
    endtask

    // pulseless steps until the stall trips; a high multiplier is dropped to
    // one mid-pass so the run stays bounded
    task automatic drive_until_stall(int cap);
        int run;
        run = 0;
        while (cal_mode != MODE_IDLE) begin
            if (run == cap) begin
                wait_drained();
                set_multiplier(4'd1);
            end
            send_tick(pass_tick(1'b0, 100, 15));
            run++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_round();
        send_tick(make_tick(1'b0, 1'b1, 1'b1, 4'd15));   // idle, ignored
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd0));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd15));   // start from idle
        send_tick(make_tick(1'b1, 1'b0, 1'b1, 4'd0));    // start in seek ignored
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd15));   // seek pulses clear count
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd7));    // top reached
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd15));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd0));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd15));   // phase wraps below zero
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd9));    // bottom, pulses still count
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd15));   // phase wraps above seven
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd3));    // round one ends
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd0));    // empty down pass
        send_tick(make_tick(1'b0, 1'b1, 1'b1, 4'd0));    // empty up pass
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd1));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0));
    endtask

    task automatic test_stall_thresholds();
        wait_drained();
        set_multiplier(4'd15);
        drive_travel(300, 100, 15, 1'b0);                // well under the limit
        wait_drained();
        set_multiplier(4'd1);
        drive_until_stall(1_000_000);                    // trips on the first step
        // fresh seek, then the limit is crossed exactly one step past it
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
        send_tick(pass_tick(1'b0, 0, 15));
        send_tick(pass_tick(1'b1, 0, 15));
        drive_until_stall(1_000_000);
    endtask

    task automatic run_attempt();
        int zero_pct;
        bit quick;
        wait_drained();
        set_multiplier(4'($urandom_range(1, 15)));
        quick    = ($urandom_range(0, 3) == 0);
        zero_pct = quick ? 100 : $urandom_range(5, 60);
        repeat ($urandom_range(0, 3)) send_tick(noise_tick(1'b0));
        send_tick(noise_tick(1'b1));
        drive_travel($urandom_range(0, 25), zero_pct, 15, 1'b1);
        while (cal_mode != MODE_IDLE) begin
            // never let the last round close here: calibration would latch
            if ((cal_mode == MODE_UP && cal_round == NUM_ROUNDS - 1) ||
                $urandom_range(0, 19) == 0) begin
                drive_until_stall(STALL_RUN_CAP);
            end else begin
                drive_travel($urandom_range(0, 20), zero_pct, 15, 1'b1);
            end
        end
    endtask

    task automatic test_random_attempts();
        int first_live;
        first_live    = live_ticks;
        long_hold_req = 1'b1;
        while (live_ticks - first_live < RANDOM_TICKS) run_attempt();
    endtask

    task automatic test_full_calibration();
        bit zero_avg;
        int zero_pct;
        int max_p;
        wait_drained();
        set_multiplier(4'd15);
        zero_avg = 1'($urandom_range(0, 1));
        zero_pct = zero_avg ? 100 : 67;
        max_p    = zero_avg ? 1 : 3;
        send_tick(noise_tick(1'b1));
        drive_travel($urandom_range(1, 10), 0, 15, 1'b1);
        repeat (2 * NUM_ROUNDS) drive_travel($urandom_range(4, 30), zero_pct, max_p, 1'b1);
        repeat (4) send_tick(noise_tick(1'b1));          // start ignored once calibrated
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_failure(input string msg);
        if (fail_count < PRINT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got !== want) begin
            report_failure($sformatf("result %0d %s: got %0d, expected %0d",
                                     results_seen, name, got, want));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (due_outputs.size() == 0) begin
                report_failure($sformatf("result transfer with no tick pending (mode %0d)",
                                         o_mode_code));
            end else begin
                head_out = due_outputs.pop_front();
                check_field("coil_phase",    o_coil_phase,    head_out.phase);
                check_field("coil_update",   o_coil_update,   head_out.update);
                check_field("mode_code",     o_mode_code,     head_out.mode);
                check_field("stall_error",   o_stall_error,   head_out.stall);
                check_field("is_calibrated", o_is_calibrated, head_out.calibrated);
                check_field("round_number",  o_round_number,  head_out.round_num);
                check_field("average_count", o_average_count, head_out.average);
                check_field("step_ratio",    o_step_ratio,    head_out.ratio);
            end
            results_seen++;
        end
    end

    // receiver: its own stall pattern, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
            out_stall    <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            out_stall <= ($urandom_range(1, 100) <= stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d ticks pending",
                     WATCHDOG_LIMIT, due_outputs.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_round();
        test_stall_thresholds();
        test_random_attempts();
        test_full_calibration();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d ticks (%0d outside idle), %0d stalls, %0d multiplier writes",
                 results_seen, live_ticks, stalls_predicted, cfg_writes);
        $display("Calibrations completed: %0d, final average %0d, final ratio %0d",
                 calibrations_done, cal_avg, cal_ratio);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
